FILE: rtl/ppc_pkg.sv
package ppc_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned REQ_W           = 2;
  localparam int unsigned REG_W           = 31;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned FRAC_BITS       = 16;

  // Register reset values (Q16.16).
  localparam logic [REG_W-1:0] GAIN_RESET      = REG_W'(65536);
  localparam logic [REG_W-1:0] DEADBAND_RESET  = REG_W'(655);
  localparam logic [REG_W-1:0] MAX_SPEED_RESET = REG_W'(65536);

  // Serial arithmetic widths: multiplicand, radicand and root.
  localparam int unsigned MUL_AW = 32;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned ROOT_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_POSE   = 2'd0,
    REQ_TARGET = 2'd1,
    REQ_TICK   = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_GAIN = 2'd0,
    CFG_DEADBAND   = 2'd1,
    CFG_MAX_SPEED  = 2'd2
  } cfg_idx_e;

endpackage

FILE: rtl/position_p_controller.sv
// Three-axis proportional position controller, signed Q16.16.
// Input channel (in_valid_i / in_stall_o) carries one request per transaction:
// a pose update (stores x, y, z, yaw; the first one also sets the target),
// a target update, or a tick. Pose and target updates give no result. A tick
// produces one result transaction on the output channel
// (out_valid_o / out_stall_i): vel_x, vel_y, vel_z and yaw_rate.
// A tick runs through bit-serial multipliers (one multiplier bit per cycle,
// multiplier width BW = max(COORD_WIDTH+1, 32)), an isqrt unit and, when the
// horizontal clamp engages, a scaling multiply and two restoring dividers.
// Horizontal commands above 2^31 are first shifted down with one common
// shift. One tick is in flight at a time; in_stall_o stays high until its
// result is in the output register.
// The output register holds a result while out_stall_i is high; new requests
// are taken meanwhile, and a following tick waits for the register to free.
// Reset clears pose, target and status and loads the default gain (1.0),
// deadband and speed limit. The configuration port writes a register per
// cycle with cfg_we_i; write it only while no tick is in progress.
module position_p_controller #(
  parameter int unsigned COORD_WIDTH = ppc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ppc_pkg::REQ_W-1:0]       req_type_i,
  input  logic signed [COORD_WIDTH-1:0]   pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]   pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]   pos_z_i,
  input  logic signed [COORD_WIDTH-1:0]   yaw_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [COORD_WIDTH-1:0]   vel_x_o,
  output logic signed [COORD_WIDTH-1:0]   vel_y_o,
  output logic signed [COORD_WIDTH-1:0]   vel_z_o,
  output logic signed [COORD_WIDTH-1:0]   yaw_rate_o,
  input  logic                            cfg_we_i,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ppc_pkg::REG_W-1:0]       cfg_data_i
);
  import ppc_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned EW   = W + 1;
  localparam int unsigned BW   = (EW > MUL_AW) ? EW : MUL_AW;
  localparam int unsigned PW   = MUL_AW + BW;
  localparam int unsigned PSW  = PW - FRAC_BITS;
  localparam int unsigned SW   = (W > MUL_AW) ? W : MUL_AW;
  localparam int unsigned DCW  = (EW > REG_W) ? EW : REG_W;
  localparam int unsigned LCW  = (W > REG_W) ? W : REG_W;
  localparam int unsigned NAX  = 3;
  localparam int unsigned NHZ  = 2;

  localparam logic [PSW-1:0] NEG_LIM  = PSW'(1) << (W - 1);
  localparam logic [PSW-1:0] POS_LIM  = NEG_LIM - PSW'(1);
  localparam logic [SW-1:0]  HALF_RNG = SW'(64'h0000_0000_8000_0000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_SHIFT,
    ST_SQUARE,
    ST_ROOT,
    ST_SCALE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Configuration and controller state.
  logic [REG_W-1:0]    gain_q;
  logic [REG_W-1:0]    dband_q;
  logic [REG_W-1:0]    lim_q;
  logic signed [W-1:0] cur_q [NAX];
  logic signed [W-1:0] tgt_q [NAX];
  logic signed [W-1:0] yaw_q;
  logic                seen_q;
  logic signed [W-1:0] pos_in [NAX];

  // Tick datapath.
  logic [EW-1:0]       mag_q  [NAX];
  logic [NAX-1:0]      eneg_q;
  logic signed [W-1:0] vel_q  [NAX];
  logic signed [W-1:0] yr_q;
  logic [SW-1:0]       sx_q   [NHZ];
  logic                pre_over_q;
  logic [SQ_W-1:0]     sum_q;
  logic signed [W-1:0] out_q  [NAX];
  logic signed [W-1:0] out_yr_q;
  logic                out_valid_q;

  logic                mul_start_q;
  logic                sqrt_start_q;
  logic                div_start_q;

  logic signed [EW-1:0] err      [NAX];
  logic [EW-1:0]        mag_d    [NAX];
  logic signed [W-1:0]  yaw_bias;
  logic signed [W-1:0]  yaw_div;
  logic [PSW-1:0]       ps       [NAX];
  logic [PSW-1:0]       sat_lim  [NAX];
  logic [PSW-1:0]       mag_c    [NAX];
  logic [W-1:0]         msat     [NAX];
  logic signed [W-1:0]  vel_d    [NAX];
  logic                 pre_over_d;
  logic                 need_shift;
  logic                 over;
  logic                 out_free;
  logic                 in_acc;

  logic [MUL_AW-1:0]    mul_a    [NAX];
  logic [BW-1:0]        mul_b    [NAX];
  logic [PW-1:0]        prod     [NAX];
  logic [NAX-1:0]       mul_done;
  logic                 sqrt_done;
  logic [ROOT_W-1:0]    root;
  logic                 rem_nz;
  logic [NHZ-1:0]       div_done;
  logic [SQ_W-1:0]      quot     [NHZ];

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Axis error magnitudes, yaw rate truncated toward zero.
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      err[i]   = $signed({tgt_q[i][W-1], tgt_q[i]}) - $signed({cur_q[i][W-1], cur_q[i]});
      mag_d[i] = err[i][W] ? -err[i] : err[i];
    end
    yaw_bias = yaw_q[W-1] ? (yaw_q + W'(7)) : yaw_q;
    yaw_div  = yaw_bias >>> 3;
  end

  // Axis commands from the product: drop fraction, saturate, deadband.
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      ps[i]      = prod[i][PW-1:FRAC_BITS];
      sat_lim[i] = eneg_q[i] ? NEG_LIM : POS_LIM;
      mag_c[i]   = (ps[i] > sat_lim[i]) ? sat_lim[i] : ps[i];
      if (DCW'(mag_q[i]) < DCW'(dband_q)) begin
        msat[i] = '0;
      end else begin
        msat[i] = mag_c[i][W-1:0];
      end
      vel_d[i] = eneg_q[i] ? -msat[i] : msat[i];
    end
    pre_over_d = (LCW'(msat[0]) > LCW'(lim_q)) || (LCW'(msat[1]) > LCW'(lim_q));
  end

  assign need_shift = (sx_q[0] > HALF_RNG) || (sx_q[1] > HALF_RNG);
  assign over = pre_over_q || (root > ROOT_W'(lim_q)) ||
                ((root == ROOT_W'(lim_q)) && rem_nz);

  // Operand select for the serial multipliers; the two horizontal ones are shared by the axis, square and scale passes.
  always_comb begin
    for (int i = 0; i < NHZ; i++) begin
      unique case (state_q)
        ST_SQUARE: begin
          mul_a[i] = sx_q[i][MUL_AW-1:0];
          mul_b[i] = BW'(sx_q[i][MUL_AW-1:0]);
        end
        ST_SCALE: begin
          mul_a[i] = MUL_AW'(lim_q);
          mul_b[i] = BW'(sx_q[i][MUL_AW-1:0]);
        end
        default: begin
          mul_a[i] = MUL_AW'(gain_q);
          mul_b[i] = BW'(mag_q[i]);
        end
      endcase
    end
    mul_a[2] = MUL_AW'(gain_q);
    mul_b[2] = BW'(mag_q[2]);
  end

  for (genvar g = 0; g < NAX; g++) begin : g_mul
    ppc_mul #(
      .AW (MUL_AW),
      .BW (BW)
    ) u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (mul_start_q),
      .a_i     (mul_a[g]),
      .b_i     (mul_b[g]),
      .done_o  (mul_done[g]),
      .prod_o  (prod[g])
    );
  end

  ppc_isqrt u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sqrt_start_q),
    .rad_i    (sum_q),
    .done_o   (sqrt_done),
    .root_o   (root),
    .rem_nz_o (rem_nz)
  );

  for (genvar g = 0; g < NHZ; g++) begin : g_div
    ppc_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start_q),
      .dividend_i (prod[g][SQ_W-1:0]),
      .divisor_i  (root),
      .done_o     (div_done[g]),
      .quot_o     (quot[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gain_q       <= GAIN_RESET;
      dband_q      <= DEADBAND_RESET;
      lim_q        <= MAX_SPEED_RESET;
      yaw_q        <= '0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      mul_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      for (int i = 0; i < NAX; i++) begin
        cur_q[i] <= '0;
        tgt_q[i] <= '0;
      end
    end else begin
      mul_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SPEED_GAIN: gain_q  <= cfg_data_i;
          CFG_DEADBAND:   dband_q <= cfg_data_i;
          CFG_MAX_SPEED:  lim_q   <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (req_type_i)
              REQ_POSE: begin
                for (int i = 0; i < NAX; i++) begin
                  cur_q[i] <= pos_in[i];
                  if (!seen_q) begin
                    tgt_q[i] <= pos_in[i];
                  end
                end
                yaw_q  <= yaw_in_i;
                seen_q <= 1'b1;
              end
              REQ_TARGET: begin
                for (int i = 0; i < NAX; i++) begin
                  tgt_q[i] <= pos_in[i];
                end
              end
              REQ_TICK: begin
                state_q     <= ST_AXIS;
                mul_start_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_AXIS: begin
          if (&mul_done) begin
            state_q <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (!need_shift) begin
            state_q      <= ST_SQUARE;
            mul_start_q  <= 1'b1;
          end
        end
        ST_SQUARE: begin
          if (&mul_done) begin
            state_q      <= ST_ROOT;
            sqrt_start_q <= 1'b1;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            if (over && (root != '0)) begin
              state_q     <= ST_SCALE;
              mul_start_q <= 1'b1;
            end else begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_SCALE: begin
          if (&mul_done) begin
            state_q     <= ST_DIVIDE;
            div_start_q <= 1'b1;
          end
        end
        ST_DIVIDE: begin
          if (&div_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (req_type_i == REQ_TICK)) begin
          for (int i = 0; i < NAX; i++) begin
            mag_q[i]  <= mag_d[i];
            eneg_q[i] <= err[i][W];
          end
          yr_q <= -yaw_div;
        end
      end
      ST_AXIS: begin
        if (&mul_done) begin
          for (int i = 0; i < NAX; i++) begin
            vel_q[i] <= vel_d[i];
          end
          for (int i = 0; i < NHZ; i++) begin
            sx_q[i] <= SW'(msat[i]);
          end
          pre_over_q <= pre_over_d;
        end
      end
      ST_SHIFT: begin
        // Bring both magnitudes to at most 2^31 with one common shift.
        if (need_shift) begin
          for (int i = 0; i < NHZ; i++) begin
            sx_q[i] <= sx_q[i] >> 1;
          end
        end
      end
      ST_SQUARE: begin
        if (&mul_done) begin
          sum_q <= prod[0][SQ_W-1:0] + prod[1][SQ_W-1:0];
        end
      end
      ST_ROOT: begin
        if (sqrt_done && over && (root == '0)) begin
          vel_q[0] <= '0;
          vel_q[1] <= '0;
        end
      end
      ST_DIVIDE: begin
        if (&div_done) begin
          for (int i = 0; i < NHZ; i++) begin
            vel_q[i] <= vel_q[i][W-1] ? -quot[i][W-1:0] : quot[i][W-1:0];
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          for (int i = 0; i < NAX; i++) begin
            out_q[i] <= vel_q[i];
          end
          out_yr_q <= yr_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign vel_x_o     = out_q[0];
  assign vel_y_o     = out_q[1];
  assign vel_z_o     = out_q[2];
  assign yaw_rate_o  = out_yr_q;

endmodule

FILE: rtl/ppc_mul.sv
module ppc_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned PW   = AW + BW;
  localparam int unsigned CNTW = $clog2(BW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [PW-1:0]   acc_q;
  logic [PW-1:0]   a_q;
  logic [BW-1:0]   b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One multiplier bit per cycle, LSB first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= PW'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: rtl/ppc_isqrt.sv
module ppc_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ppc_pkg::SQ_W-1:0]   rad_i,
  output logic                       done_o,
  output logic [ppc_pkg::ROOT_W-1:0] root_o,
  output logic                       rem_nz_o
);
  import ppc_pkg::*;

  localparam int unsigned REMW = ROOT_W + 2;
  localparam int unsigned CNTW = $clog2(ROOT_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNTW-1:0]   cnt_q;
  logic [SQ_W-1:0]   rad_q;
  logic [REMW-1:0]   rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REMW+1:0]   rem_sh;
  logic [REMW+1:0]   trial;
  logic              fit;

  // Bring down two radicand bits, try root*4+1.
  assign rem_sh = {rem_q, rad_q[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fit    = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (fit) begin
        rem_q  <= REMW'(rem_sh - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[REMW-1:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o   = done_q;
  assign root_o   = root_q;
  assign rem_nz_o = |rem_q;

endmodule

FILE: rtl/ppc_div.sv
module ppc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ppc_pkg::SQ_W-1:0]   dividend_i,
  input  logic [ppc_pkg::ROOT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [ppc_pkg::SQ_W-1:0]   quot_o
);
  import ppc_pkg::*;

  localparam int unsigned CNTW = $clog2(SQ_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNTW-1:0]   cnt_q;
  logic [SQ_W-1:0]   dq_q;
  logic [ROOT_W-1:0] rem_q;
  logic [ROOT_W-1:0] dvs_q;
  logic [ROOT_W:0]   rem_sh;
  logic              ge;

  // Restoring division: dividend bits shift out the top, quotient bits in the bottom.
  assign rem_sh = {rem_q, dq_q[SQ_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(SQ_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= ROOT_W'(rem_sh - {1'b0, dvs_q});
      end else begin
        rem_q <= rem_sh[ROOT_W-1:0];
      end
      dq_q <= {dq_q[SQ_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
